@@ rtl/cffisp_pkg.sv @@
package cffisp_pkg;

   localparam int MAX_ELEMENTS = 1024;

   // element numbers inside one index
   localparam int ELEM_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   // offset positions run 0..MAX_ELEMENTS
   localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
   localparam int ADDR_W = ELEM_W;
   localparam int OFF_W = 32;
   localparam int CMP_W = 17;

   typedef enum logic [2:0] {
      PH_COUNT_HI = 3'd0,
      PH_COUNT_LO = 3'd1,
      PH_OFFSIZE  = 3'd2,
      PH_OFFSETS  = 3'd3,
      PH_DATA     = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_OFFSIZE = 2'd1,
      ERR_COUNT   = 2'd2,
      ERR_OFFSET  = 2'd3
   } err_type;

   // one non-empty element: its number and the offset just past its data
   typedef struct packed {
      logic [ELEM_W-1:0] elem;
      logic [OFF_W-1:0]  end_off;
   } span_type;

   typedef struct packed {
      logic [15:0] elem;
      logic [7:0]  data;
      logic        byte_valid;
      logic        last;
      logic        done;
      err_type     err;
   } rsp_type;

endpackage

@@ rtl/cff_index_stream_parser.sv @@
// Font INDEX stream parser.
// req_ channel: one stream byte per beat (req_in_byte). rsp_ channel: one
// result per beat: element number, data byte with byte_valid, element_last,
// index_done and error_code. Count, offset size and non-final offset bytes
// give no result; data bytes, empty-element markers, index ends and errors
// give exactly one.
// Throughput is one byte per cycle in every phase while the receiver keeps
// taking results. A result sits in the output register the cycle after its byte is taken.
// Non-empty elements are written as spans {element, end offset} into one
// synchronous memory of MAX_ELEMENTS entries while the offsets arrive; the
// data phase walks that memory in order, holding the current span in a
// register and the next one at the memory's registered read port, so an
// element of one byte can follow another without a bubble. A span written
// in the cycle it is read is forwarded.
// Reset returns the parser to expecting the count of a new index and clears
// the output valid flag; the span memory is not cleared (it is always written
// before its contents are used).
// When the receiver stalls, the result holds in the output register and
// req_ready drops until it is taken; a new byte is taken in the same cycle
// as the waiting result leaves.
module cff_index_stream_parser (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_in_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [15:0]                rsp_element_number,
   output logic [7:0]                 rsp_data_byte,
   output logic                       rsp_byte_valid,
   output logic                       rsp_element_last,
   output logic                       rsp_index_done,
   output logic [1:0]                 rsp_error_code
);
   import cffisp_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [15:0]        count_ff, count_in;
   logic [2:0]         width_ff, width_in;
   logic [1:0]         bcnt_ff, bcnt_in;
   logic [23:0]        acc_ff, acc_in;
   logic [CNT_W-1:0]   oc_ff, oc_in;
   logic [OFF_W-1:0]   prev_ff, prev_in;
   logic [CNT_W-1:0]   nz_ff, nz_in;
   logic [OFF_W-1:0]   pos_ff, pos_in;
   span_type           cur_ff, cur_in;
   logic [CNT_W-1:0]   cur_idx_ff, cur_idx_in;
   logic [CNT_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   span_type           span_mem [MAX_ELEMENTS];
   span_type           mem_q_ff;
   span_type           wq_ff;
   logic               fwd_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [ADDR_W-1:0]  mem_raddr;
   span_type           mem_wdata;
   span_type           nxt;

   logic               req_fire;
   logic [7:0]         b;
   logic [15:0]        count_full;
   logic               cnt_zero, cnt_big, size_bad;
   logic [OFF_W-1:0]   off_val;
   logic               off_final, off_err, off_end, off_empty, all_empty;
   logic [OFF_W:0]     pos_next;
   logic               data_last, elem_end;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign b         = req_in_byte;
   assign nxt       = fwd_ff ? wq_ff : mem_q_ff;

   // decode of the current byte against the parser state
   always_comb begin
      count_full = {count_ff[15:8], b};
      cnt_zero   = count_full == 16'd0;
      cnt_big    = count_full > 16'(MAX_ELEMENTS);
      size_bad   = (b == 8'd0) || (b > 8'd4);
      off_val    = {acc_ff, b};
      off_final  = ({1'b0, bcnt_ff} + 3'd1) >= width_ff;
      off_err    = ((oc_ff == '0) && (off_val != 32'd1)) ||
                   ((oc_ff != '0) && (off_val < prev_ff));
      off_empty  = (oc_ff != '0) && (off_val == prev_ff);
      off_end    = CMP_W'(oc_ff) == CMP_W'(count_ff);
      all_empty  = off_val == 32'd1;
      pos_next   = {1'b0, pos_ff} + 33'd1;
      data_last  = pos_next == {1'b0, cur_ff.end_off};
      elem_end   = (cur_idx_ff + CNT_W'(1)) == nz_ff;
   end

   always_comb begin
      phase_in = phase_ff;
      if (req_fire) begin
         case (phase_ff)
            PH_COUNT_LO: phase_in = (cnt_zero || cnt_big) ? PH_COUNT_HI : PH_OFFSIZE;
            PH_OFFSIZE:  phase_in = size_bad ? PH_COUNT_HI : PH_OFFSETS;
            PH_OFFSETS: begin
               if (off_final) begin
                  if (off_err) begin
                     phase_in = PH_COUNT_HI;
                  end else if (off_end) begin
                     phase_in = all_empty ? PH_COUNT_HI : PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               if (data_last && elem_end) begin
                  phase_in = PH_COUNT_HI;
               end
            end
            default: phase_in = PH_COUNT_LO;
         endcase
      end
   end

   always_comb begin
      count_in     = count_ff;
      width_in     = width_ff;
      bcnt_in      = bcnt_ff;
      acc_in       = acc_ff;
      oc_in        = oc_ff;
      prev_in      = prev_ff;
      nz_in        = nz_ff;
      pos_in       = pos_ff;
      cur_in       = cur_ff;
      cur_idx_in   = cur_idx_ff;
      rd_ptr_in    = rd_ptr_ff;
      rsp_in       = '0;
      rsp_in.err   = ERR_NONE;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      mem_waddr    = nz_ff[ADDR_W-1:0];
      mem_wdata.elem    = ELEM_W'(oc_ff - CNT_W'(1));
      mem_wdata.end_off = off_val;
      if (req_fire) begin
         rsp_valid_in = 1'b0;
         case (phase_ff)
            PH_COUNT_LO: begin
               count_in = count_full;
               if (cnt_zero) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.done  = 1'b1;
               end else if (cnt_big) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.err   = ERR_COUNT;
               end
            end
            PH_OFFSIZE: begin
               if (size_bad) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.err   = ERR_OFFSIZE;
               end else begin
                  width_in  = b[2:0];
                  bcnt_in   = 2'd0;
                  acc_in    = '0;
                  oc_in     = '0;
                  nz_in     = '0;
                  rd_ptr_in = CNT_W'(1);
               end
            end
            PH_OFFSETS: begin
               if (!off_final) begin
                  bcnt_in = bcnt_ff + 2'd1;
                  acc_in  = off_val[23:0];
               end else begin
                  bcnt_in = 2'd0;
                  acc_in  = '0;
                  if (off_err) begin
                     rsp_valid_in = 1'b1;
                     rsp_in.elem  = 16'(oc_ff);
                     rsp_in.err   = ERR_OFFSET;
                  end else begin
                     prev_in = off_val;
                     oc_in   = oc_ff + CNT_W'(1);
                     // strictly rising offset closes a non-empty element
                     if (oc_ff != '0 && !off_empty) begin
                        mem_we = 1'b1;
                        nz_in  = nz_ff + CNT_W'(1);
                        if (nz_ff == '0) begin
                           cur_in = mem_wdata;
                        end
                     end
                     if (off_empty) begin
                        rsp_valid_in = 1'b1;
                        rsp_in.elem  = 16'(oc_ff - CNT_W'(1));
                        rsp_in.last  = 1'b1;
                        rsp_in.done  = off_end && all_empty;
                     end
                     if (off_end) begin
                        pos_in     = 32'd1;
                        cur_idx_in = '0;
                     end
                  end
               end
            end
            PH_DATA: begin
               rsp_valid_in      = 1'b1;
               rsp_in.elem       = 16'(cur_ff.elem);
               rsp_in.data       = b;
               rsp_in.byte_valid = 1'b1;
               rsp_in.last       = data_last;
               rsp_in.done       = data_last && elem_end;
               pos_in            = pos_ff + 32'd1;
               if (data_last) begin
                  cur_in     = nxt;
                  cur_idx_in = cur_idx_ff + CNT_W'(1);
                  rd_ptr_in  = rd_ptr_ff + CNT_W'(1);
               end
            end
            default: begin
               count_in = {b, 8'h00};
            end
         endcase
      end
   end

   // the read port follows the span after the current one
   assign mem_raddr = rd_ptr_in[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         span_mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= span_mem[mem_raddr];
      wq_ff    <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_COUNT_HI;
         rsp_valid_ff <= 1'b0;
         fwd_ff       <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_ff       <= mem_we && (mem_waddr == mem_raddr);
      end
   end

   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      width_ff   <= width_in;
      bcnt_ff    <= bcnt_in;
      acc_ff     <= acc_in;
      oc_ff      <= oc_in;
      prev_ff    <= prev_in;
      nz_ff      <= nz_in;
      pos_ff     <= pos_in;
      cur_ff     <= cur_in;
      cur_idx_ff <= cur_idx_in;
      rd_ptr_ff  <= rd_ptr_in;
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_element_number = rsp_ff.elem;
   assign rsp_data_byte      = rsp_ff.data;
   assign rsp_byte_valid     = rsp_ff.byte_valid;
   assign rsp_element_last   = rsp_ff.last;
   assign rsp_index_done     = rsp_ff.done;
   assign rsp_error_code     = rsp_ff.err;

endmodule
